[src/fpasm_pkg.sv]
// Package: shared types and constants for the binary32 add/subtract/multiply unit.
package fpasm_pkg;
    localparam int FRAC_BITS = 23;
    localparam int ADD_GUARD = 7;
    localparam int EXP_BIAS  = 127;

    typedef struct packed {
        logic        zero_res;   // result fixed before normalize
        logic [31:0] fixed_word;
        logic        fixed_ovf;
        logic        sign;
        logic [47:0] mag;
        logic signed [10:0] ebase;
    } fpasm_raw_t;
endpackage

[src/fpasm_front.sv]
// Front stages: decode, align and add, or multiply the significands.
module fpasm_front
    import fpasm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [1:0]  action,
    input  logic [31:0] a_value,
    input  logic [31:0] b_value,
    output logic        out_valid,
    output fpasm_raw_t  out_raw
);
    logic        s1_valid_reg;
    logic        s1_mul_reg;
    logic        s1_sa_reg, s1_sb_reg;
    logic [7:0]  s1_ea_reg, s1_eb_reg;
    logic [22:0] s1_fa_reg, s1_fb_reg;
    logic        valid_reg;
    fpasm_raw_t  raw_reg, raw_next;
    logic [47:0] prod_reg;
    logic        s2_mul_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            valid_reg    <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_mul_reg <= action[1];
        s1_sa_reg  <= a_value[31];
        s1_sb_reg  <= b_value[31] ^ (~action[1] & action[0]);
        s1_ea_reg  <= a_value[30:23];
        s1_eb_reg  <= b_value[30:23];
        s1_fa_reg  <= a_value[22:0];
        s1_fb_reg  <= b_value[22:0];
        raw_reg    <= raw_next;
        prod_reg   <= {24'd0, 1'b1, s1_fa_reg} * {24'd0, 1'b1, s1_fb_reg};
        s2_mul_reg <= s1_mul_reg;
    end

    logic [30:0] ma, mb, ma_sh, mb_sh;
    logic [7:0]  d, emax;
    logic [31:0] mc;
    logic        sc;

    always_comb
    begin
        ma = {1'b1, s1_fa_reg, 7'd0};
        mb = {1'b1, s1_fb_reg, 7'd0};
        ma_sh = ma;
        mb_sh = mb;
        emax = s1_ea_reg;
        d = 8'd0;
        if (s1_ea_reg > s1_eb_reg)
        begin
            d = s1_ea_reg - s1_eb_reg;
            mb_sh = (d >= 8'd32) ? 31'd0 : (mb >> d);
        end
        else if (s1_eb_reg > s1_ea_reg)
        begin
            d = s1_eb_reg - s1_ea_reg;
            ma_sh = (d >= 8'd32) ? 31'd0 : (ma >> d);
            emax = s1_eb_reg;
        end
        sc = s1_sa_reg;
        if (s1_sa_reg == s1_sb_reg)
            mc = {1'b0, ma_sh} + {1'b0, mb_sh};
        else if (ma_sh >= mb_sh)
            mc = {1'b0, ma_sh - mb_sh};
        else
        begin
            mc = {1'b0, mb_sh - ma_sh};
            sc = s1_sb_reg;
        end

        raw_next = '0;
        raw_next.sign = sc;
        raw_next.mag = {16'd0, mc};
        raw_next.ebase = $signed({3'd0, emax}) - 11'sd7;
        if (s1_mul_reg)
        begin
            raw_next.sign = s1_sa_reg ^ s1_sb_reg;
            raw_next.ebase = $signed({3'd0, s1_ea_reg}) + $signed({3'd0, s1_eb_reg})
                             - 11'sd150;
            if (s1_ea_reg == 8'd0 || s1_eb_reg == 8'd0)
            begin
                raw_next.zero_res = 1'b1;
                raw_next.fixed_word = {s1_sa_reg ^ s1_sb_reg, 31'd0};
            end
        end
        else if (s1_ea_reg == 8'd0 && s1_eb_reg == 8'd0)
        begin
            raw_next.zero_res = 1'b1;
            raw_next.fixed_word = {s1_sa_reg & s1_sb_reg, 31'd0};
        end
        else if (s1_ea_reg == 8'd0 || s1_eb_reg == 8'd0)
        begin
            raw_next.zero_res = 1'b1;
            if (s1_ea_reg == 8'd0)
            begin
                raw_next.fixed_word = {s1_sb_reg, s1_eb_reg, s1_fb_reg};
                raw_next.fixed_ovf  = (s1_eb_reg == 8'hFF);
            end
            else
            begin
                raw_next.fixed_word = {s1_sa_reg, s1_ea_reg, s1_fa_reg};
                raw_next.fixed_ovf  = (s1_ea_reg == 8'hFF);
            end
            if (raw_next.fixed_ovf)
                raw_next.fixed_word[22:0] = 23'd0;
        end
        else if (mc == 32'd0)
        begin
            raw_next.zero_res = 1'b1;
            raw_next.fixed_word = 32'd0;
        end
    end

    always_comb
    begin
        out_raw = raw_reg;
        if (s2_mul_reg && !raw_reg.zero_res)
            out_raw.mag = prod_reg;
    end
    assign out_valid = valid_reg;
endmodule

[src/fpasm_norm.sv]
// Back stages: leading-one search, round and pack.
module fpasm_norm
    import fpasm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  fpasm_raw_t  in_raw,
    output logic        done,
    output logic [31:0] result_value,
    output logic        overflow_flag,
    output logic        underflow_flag
);
    logic       v3_reg, v4_reg;
    fpasm_raw_t r3_reg;
    logic [5:0] p3_reg, p_next;
    logic [31:0] word_reg, word_next;
    logic       ovf_reg, ovf_next, unf_reg, unf_next;

    always_comb
    begin
        p_next = 6'd0;
        for (int i = 0; i < 48; i++)
            if (in_raw.mag[i])
                p_next = 6'(i);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= in_valid;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        r3_reg   <= in_raw;
        p3_reg   <= p_next;
        word_reg <= word_next;
        ovf_reg  <= ovf_next;
        unf_reg  <= unf_next;
    end

    logic signed [11:0] e;
    logic [47:0] shv, sh_m1;
    logic [24:0] r;
    logic [5:0]  sh;

    always_comb
    begin
        e = 12'(r3_reg.ebase) + $signed({6'd0, p3_reg}) - 12'sd23;
        sh = 6'd0;
        shv = '0;
        sh_m1 = '0;
        r = '0;
        if (p3_reg > 6'd23)
        begin
            sh = p3_reg - 6'd23;
            shv = r3_reg.mag >> sh;
            sh_m1 = r3_reg.mag >> (sh - 6'd1);
            r = shv[24:0] + {24'd0, sh_m1[0]};
            if (r[24])
            begin
                r = r >> 1;
                e = e + 12'sd1;
            end
        end
        else
        begin
            shv = r3_reg.mag << (6'd23 - p3_reg);
            r = shv[24:0];
        end
        ovf_next = 1'b0;
        unf_next = 1'b0;
        if (r3_reg.zero_res)
        begin
            word_next = r3_reg.fixed_word;
            ovf_next  = r3_reg.fixed_ovf;
            if (r3_reg.fixed_ovf)
                word_next = {r3_reg.fixed_word[31], 31'h7F800000};
        end
        else if (e >= 12'sd255)
        begin
            word_next = {r3_reg.sign, 31'h7F800000};
            ovf_next = 1'b1;
        end
        else if (e < 12'sd1)
        begin
            word_next = {r3_reg.sign, 31'd0};
            unf_next = 1'b1;
        end
        else
            word_next = {r3_reg.sign, e[7:0], r[22:0]};
    end

    assign done = v4_reg;
    assign result_value = word_reg;
    assign overflow_flag = ovf_reg;
    assign underflow_flag = unf_reg;

`ifndef NO_ASSERTIONS
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(overflow_flag && underflow_flag)) else $error("both flags");
    a_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |=> ##1 done) else $error("lost word");
    a_inf: assert property (@(posedge clk) disable iff (!rst_n)
        (done && overflow_flag) |-> result_value[30:0] == 31'h7F800000)
        else $error("bad inf");
`endif
endmodule

[src/fp32_add_sub_mul.sv]
// Top level: pipelined binary32 add, subtract and multiply unit.
// A word is registered in the decode, add/multiply, leading-one and pack stages before the done strobe.
// Throughput: one word per cycle; busy stays low, the pipeline never stalls.
// Each result stands on the outputs for one cycle with done high.
// Reset clears all valid bits asynchronously; data registers are not reset.
module fp32_add_sub_mul
    import fpasm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [31:0] a_value,
    input  logic [31:0] b_value,
    output logic        done,
    output logic [31:0] result_value,
    output logic        overflow_flag,
    output logic        underflow_flag
);
    logic       raw_valid;
    fpasm_raw_t raw;

    assign busy = 1'b0;

    fpasm_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(start && !busy),
        .action(action), .a_value(a_value), .b_value(b_value),
        .out_valid(raw_valid), .out_raw(raw)
    );

    fpasm_norm u_norm (
        .clk(clk), .rst_n(rst_n), .in_valid(raw_valid), .in_raw(raw),
        .done(done), .result_value(result_value),
        .overflow_flag(overflow_flag), .underflow_flag(underflow_flag)
    );
endmodule

[tb/fp32_add_sub_mul_tb.sv]
// Testbench for the pipelined binary32 add, subtract and multiply unit.
`timescale 1ns / 100ps

module fp32_add_sub_mul_tb;
    import fpasm_pkg::*;

    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_SUB = 2'd1;
    localparam logic [1:0] ACT_MUL = 2'd2;
    localparam logic [1:0] ACT_MUL_ALT = 2'd3;
    localparam int RANDOM_WORDS = 1030;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [31:0] word;
        logic        ovf;
        logic        unf;
    } fp_out_t;

    typedef struct {
        logic [1:0]  act;
        logic [31:0] a;
        logic [31:0] b;
        logic        typed;
        fp_out_t     want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  action;
    logic [31:0] a_value;
    logic [31:0] b_value;
    logic        done;
    logic [31:0] result_value;
    logic        overflow_flag;
    logic        underflow_flag;

    fp_out_t   pending_results[$];
    stim_row_t directed_rows[$];
    int        error_count = 0;

    fp32_add_sub_mul i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .a_value       (a_value),
        .b_value       (b_value),
        .done          (done),
        .result_value  (result_value),
        .overflow_flag (overflow_flag),
        .underflow_flag(underflow_flag)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic fp_out_t fp_pack(logic s, int e, logic [31:0] m);
        fp_out_t r;
        r.ovf = 1'b0;
        r.unf = 1'b0;
        if (e >= 255)
        begin
            r.word = {s, 8'hFF, 23'd0};
            r.ovf = 1'b1;
        end
        else if (e < 1)
        begin
            r.word = {s, 31'd0};
            r.unf = 1'b1;
        end
        else
            r.word = {s, e[7:0], m[22:0]};
        return r;
    endfunction

    function automatic fp_out_t fp_normalize(logic s, logic [63:0] v, int ebase);
        int          p;
        int          e;
        int          sh;
        logic [63:0] r;
        p = 63;
        while (p > 0 && v[p] == 1'b0)
            p--;
        e = ebase + p - 23;
        if (p > 23)
        begin
            sh = p - 23;
            r = (v >> sh) + ((v >> (sh - 1)) & 64'd1);
            if (r[24])
            begin
                r = r >> 1;
                e++;
            end
        end
        else
            r = v << (23 - p);
        return fp_pack(s, e, r[31:0]);
    endfunction

    function automatic fp_out_t fp_sum(logic [31:0] a, logic [31:0] b);
        logic [7:0]  ea;
        logic [7:0]  eb;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] mc;
        logic        sc;
        int          d;
        fp_out_t     r;
        ea = a[30:23];
        eb = b[30:23];
        if (ea == 0 && eb == 0)
        begin
            r.word = {a[31] & b[31], 31'd0};
            r.ovf = 1'b0;
            r.unf = 1'b0;
            return r;
        end
        if (ea == 0)
            return fp_pack(b[31], eb, b);
        if (eb == 0)
            return fp_pack(a[31], ea, a);
        ma = {1'b1, a[22:0]} << ADD_GUARD;
        mb = {1'b1, b[22:0]} << ADD_GUARD;
        if (ea > eb)
        begin
            d = ea - eb;
            mb = (d >= 32) ? 32'd0 : mb >> d;
        end
        else if (eb > ea)
        begin
            d = eb - ea;
            ma = (d >= 32) ? 32'd0 : ma >> d;
            ea = eb;
        end
        if (a[31] == b[31])
        begin
            mc = ma + mb;
            sc = a[31];
        end
        else if (ma > mb)
        begin
            mc = ma - mb;
            sc = a[31];
        end
        else if (mb > ma)
        begin
            mc = mb - ma;
            sc = b[31];
        end
        else
        begin
            r.word = 32'd0;
            r.ovf = 1'b0;
            r.unf = 1'b0;
            return r;
        end
        return fp_normalize(sc, {32'd0, mc}, int'(ea) - ADD_GUARD);
    endfunction

    function automatic fp_out_t fp_compute(logic [1:0] act, logic [31:0] a, logic [31:0] b);
        logic        sc;
        logic [63:0] prod;
        fp_out_t     r;
        if (act[1])
        begin
            sc = a[31] ^ b[31];
            if (a[30:23] == 0 || b[30:23] == 0)
            begin
                r.word = {sc, 31'd0};
                r.ovf = 1'b0;
                r.unf = 1'b0;
                return r;
            end
            prod = {40'd0, 1'b1, a[22:0]} * {40'd0, 1'b1, b[22:0]};
            return fp_normalize(sc, prod,
                int'(a[30:23]) + int'(b[30:23]) - EXP_BIAS - FRAC_BITS);
        end
        if (act[0])
            return fp_sum(a, {~b[31], b[30:0]});
        return fp_sum(a, b);
    endfunction

    function automatic stim_row_t mk_row(logic [1:0] act, logic [31:0] a, logic [31:0] b,
                                         int typed, logic [31:0] w, int o, int u);
        stim_row_t r;
        r.act = act;
        r.a = a;
        r.b = b;
        r.typed = (typed != 0);
        r.want.word = w;
        r.want.ovf = (o != 0);
        r.want.unf = (u != 0);
        return r;
    endfunction

    function automatic logic [31:0] rand_operand();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: v[30:23] = 8'd0;
            1: v[30:23] = 8'hFF;
            2: v[30:23] = 8'($urandom_range(0, 3));
            3: v[30:23] = 8'($urandom_range(252, 255));
            4, 5: v[30:23] = 8'($urandom_range(100, 154));
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_word(logic [1:0] act, logic [31:0] a, logic [31:0] b,
                             logic typed, fp_out_t want);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        action <= act;
        a_value <= a;
        b_value <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(typed ? want : fp_compute(act, a, b));
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        fp_out_t w;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result_value);
                error_count++;
            end
            else
            begin
                w = pending_results.pop_front();
                if (result_value !== w.word || overflow_flag !== w.ovf
                    || underflow_flag !== w.unf)
                begin
                    $display("%0t: expected %h ovf %b unf %b, actual %h ovf %b unf %b",
                        $time, w.word, w.ovf, w.unf,
                        result_value, overflow_flag, underflow_flag);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        stim_row_t r;
        logic [31:0] x;
        int          k;
        int          waited;
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_ADD;
        a_value = 32'd0;
        b_value = 32'd0;

        directed_rows.push_back(mk_row(ACT_ADD, 32'h0000_0000, 32'h0000_0000, 1,
            32'h0000_0000, 0, 0));
        directed_rows.push_back(mk_row(ACT_ADD, 32'h8000_0000, 32'h8012_3456, 1,
            32'h8000_0000, 0, 0));
        directed_rows.push_back(mk_row(ACT_ADD, 32'h8000_0000, 32'h0000_0001, 1,
            32'h0000_0000, 0, 0));
        directed_rows.push_back(mk_row(ACT_ADD, 32'h0000_0000, 32'h3F80_0000, 1,
            32'h3F80_0000, 0, 0));
        directed_rows.push_back(mk_row(ACT_ADD, 32'hFFFF_FFFF, 32'h0000_0000, 1,
            32'hFF80_0000, 1, 0));
        directed_rows.push_back(mk_row(ACT_SUB, 32'h3F80_0000, 32'h3F80_0000, 1,
            32'h0000_0000, 0, 0));
        directed_rows.push_back(mk_row(ACT_SUB, 32'hBF80_0000, 32'hBF80_0000, 1,
            32'h0000_0000, 0, 0));
        directed_rows.push_back(mk_row(ACT_MUL, 32'h0000_0000, 32'hC000_0000, 1,
            32'h8000_0000, 0, 0));
        directed_rows.push_back(mk_row(ACT_MUL, 32'hBF80_0000, 32'h807F_FFFF, 1,
            32'h0000_0000, 0, 0));
        directed_rows.push_back(mk_row(ACT_MUL_ALT, 32'h3F80_0000, 32'h4000_0000, 1,
            32'h4000_0000, 0, 0));
        directed_rows.push_back(mk_row(ACT_MUL, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 1,
            32'h7F80_0000, 1, 0));
        directed_rows.push_back(mk_row(ACT_MUL, 32'h0080_0000, 32'h0080_0000, 1,
            32'h0000_0000, 0, 1));
        directed_rows.push_back(mk_row(ACT_ADD, 32'h3F80_0000, 32'h3F80_0000, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ACT_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ACT_SUB, 32'h0080_0001, 32'h0080_0000, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ACT_ADD, 32'h4F80_0000, 32'h3F80_0000, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ACT_ADD, 32'h4B80_0000, 32'h3F80_0001, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ACT_ADD, 32'h3FFF_FFFF, 32'h3400_0000, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ACT_SUB, 32'hC0A0_0000, 32'h4040_0000, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ACT_MUL, 32'h3FFF_FFFF, 32'h3FFF_FFFF, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ACT_MUL, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ACT_SUB, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].act, directed_rows[i].a, directed_rows[i].b,
                directed_rows[i].typed, directed_rows[i].want);

        for (k = 0; k < RANDOM_WORDS; k++)
        begin
            r.act = 2'($urandom_range(0, 3));
            r.a = rand_operand();
            r.b = rand_operand();
            case ($urandom_range(0, 7))
                0: r.b = r.a;
                1: r.b = {r.a[31:23], r.b[22:0]};
                2:
                begin
                    x = r.a;
                    x[30:23] = x[30:23] - 8'($urandom_range(20, 40));
                    r.b = {r.b[31], x[30:23], r.b[22:0]};
                end
                default: ;
            endcase
            send_word(r.act, r.a, r.b, 1'b0, r.want);
        end
        start <= 1'b0;

        waited = 0;
        while (pending_results.size() != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

[filelist.f]
src/fpasm_pkg.sv
src/fpasm_front.sv
src/fpasm_norm.sv
src/fp32_add_sub_mul.sv
tb/fp32_add_sub_mul_tb.sv
